// File: rtl/mcam_pkg.sv
package mcam_pkg;

  // Geometry of the block
  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field and state widths
  localparam int CH_W   = 3;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 40;
  localparam int MAG_W  = 24;
  localparam int AVG_W  = 24;
  localparam int SSQ_W  = 2 * SAMPLE_BITS;   // x^2 + y^2 + z^2 always fits here
  localparam int ROOT_W = SAMPLE_BITS + 8;   // sqrt of (sum of squares << 16)
  localparam int RM_W   = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

  localparam logic [CNT_W-1:0] COUNT_MAX         = {CNT_W{1'b1}};
  localparam logic [MAG_W-1:0] MAG_MAX           = {MAG_W{1'b1}};
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RESET = 16'd100;

  // Item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  // One channel's accumulator entry
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_UPDATE,
    ST_CHK,
    ST_REL,
    ST_DIV,
    ST_OUT
  } state_t;

  // Clamp a root to the magnitude width
  function automatic logic [MAG_W-1:0] sat_mag(input logic [ROOT_W-1:0] r);
    logic [RM_W-1:0] wide;
    wide = RM_W'(r);
    if (wide > RM_W'(MAG_MAX)) begin
      return MAG_MAX;
    end
    return MAG_W'(r);
  endfunction

endpackage

// File: rtl/mcam_ifs.sv
// Sample / report item channel
interface mcam_sample_if import mcam_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] accel_x;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, mode, channel, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, mode, channel, accel_x, accel_y, accel_z, output ready);
endinterface

// Average result channel
interface mcam_result_if import mcam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel_out;
  logic [AVG_W-1:0] average;
  logic             last;

  modport source (output valid, channel_out, average, last, input ready);
  modport sink   (input valid, channel_out, average, last, output ready);
endinterface

// Configuration write channel
interface mcam_cfg_if import mcam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] min_samples;

  modport source (output valid, min_samples, input ready);
  modport sink   (input valid, min_samples, output ready);
endinterface

// File: rtl/multichannel_accel_magnitude_averager.sv
// Sample item: load, squaring of the three axes on one multiplier, 24-step root, write back;
// the bit-serial square root is the longest step. One item is in work at a time.
// Report item: one memory read per channel checked when not released; when released,
// each channel's average comes from the 40-step divider, one channel after another.
// Reset: per-entry valid bits clear at once, so all sums and counts read zero; min_samples
// returns to 100. No memory clearing pass; the block takes items in the cycle after reset.
module multichannel_accel_magnitude_averager import mcam_pkg::*; (
  input logic          clk,
  input logic          rst,
  mcam_sample_if.sink  sample,
  mcam_result_if.source result,
  mcam_cfg_if.sink     cfg
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] min_samples;

  // Accumulator memory with registered read
  entry_t        mem [CHANNELS];
  entry_t        rd_data;
  logic          rd_vld;
  logic [CHANNELS-1:0] vld;
  entry_t        entry;
  entry_t        wr_entry;

  // Sample working registers
  addr_t                         ch;
  logic signed [SAMPLE_BITS-1:0] ax;
  logic signed [SAMPLE_BITS-1:0] ay;
  logic signed [SAMPLE_BITS-1:0] az;
  logic signed [SAMPLE_BITS-1:0] axis;
  logic signed [SSQ_W-1:0]       sq_val;
  logic [SSQ_W-1:0]              prod;
  logic [SSQ_W-1:0]              acc;
  logic [1:0]                    sq_cnt;

  // Sweep index and output register
  addr_t             idx;
  addr_t             idx_next;
  logic              out_valid;
  logic [CH_W-1:0]   out_ch;
  logic [AVG_W-1:0]  out_avg;
  logic              out_last;

  // Control from the state machine
  logic        sample_ready;
  logic        in_accept;
  logic        ch_ok;
  logic        rd_en;
  addr_t       rd_addr;
  logic        mem_we;
  logic        root_start;
  logic        div_start;
  logic        out_load;
  logic        clear_all;
  logic        idx_last;

  // Units
  logic              root_done;
  logic [ROOT_W-1:0] root_val;
  logic [SSQ_W-1:0]  radicand;
  logic              div_done;
  logic [SUM_W-1:0]  quot;
  logic [MAG_W-1:0]  mag;
  logic [SUM_W:0]    sum_ext;

  assign sample.ready = sample_ready;
  assign in_accept    = sample.valid && sample_ready;
  assign ch_ok        = (int'(sample.channel) < CHANNELS);
  assign idx_last     = (idx == addr_t'(CHANNELS - 1));

  // Configuration register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= MIN_SAMPLES_RESET;
    end else if (cfg.valid) begin
      min_samples <= cfg.min_samples;
    end
  end

  // Entry seen by the logic: never-written entries read as zero
  assign entry = rd_vld ? rd_data : '0;

  // Square of the selected axis, summed into the radicand
  always_comb begin
    case (sq_cnt)
      2'd0:    axis = ax;
      2'd1:    axis = ay;
      default: axis = az;
    endcase
  end
  assign sq_val   = axis * axis;
  assign radicand = acc + prod;

  // Read-modify-write of one entry
  assign mag              = sat_mag(root_val);
  assign sum_ext          = {1'b0, entry.sum} + (SUM_W + 1)'(mag);
  assign wr_entry.sum     = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign wr_entry.count   = entry.count + 1'b1;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    sample_ready = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = idx;
    mem_we       = 1'b0;
    root_start   = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    clear_all    = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample.valid) begin
          if (sample.mode == MODE_REPORT) begin
            idx_next   = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = ST_CHK;
          end else if (ch_ok) begin
            rd_en      = 1'b1;
            rd_addr    = addr_t'(sample.channel);
            state_next = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (sq_cnt == 2'd3) begin
          root_start = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // a full count freezes the channel
        mem_we     = (entry.count != COUNT_MAX);
        state_next = ST_IDLE;
      end
      ST_CHK: begin
        if (entry.count < min_samples) begin
          state_next = ST_IDLE;
        end else if (idx_last) begin
          idx_next   = '0;
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = ST_REL;
        end else begin
          idx_next   = idx + 1'b1;
          rd_en      = 1'b1;
          rd_addr    = idx + 1'b1;
        end
      end
      ST_REL: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || result.ready) begin
          out_load = 1'b1;
          if (idx_last) begin
            clear_all  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            rd_en      = 1'b1;
            rd_addr    = idx + 1'b1;
            state_next = ST_REL;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      idx       <= '0;
      sq_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (clear_all) begin
        vld <= '0;
      end else if (mem_we) begin
        vld[ch] <= 1'b1;
      end
      if (in_accept) begin
        sq_cnt <= '0;
      end else if (state == ST_SQUARE) begin
        sq_cnt <= sq_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ch] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  // Sample capture and squaring datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch  <= addr_t'(sample.channel);
      ax  <= sample.accel_x;
      ay  <= sample.accel_y;
      az  <= sample.accel_z;
      acc <= '0;
    end else if (state == ST_SQUARE) begin
      prod <= $unsigned(sq_val);
      if (sq_cnt != 2'd0) begin
        acc <= acc + prod;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch   <= CH_W'(idx);
      out_avg  <= (entry.count == '0) ? '0 : quot[AVG_W-1:0];
      out_last <= idx_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.channel_out = out_ch;
  assign result.average     = out_avg;
  assign result.last        = out_last;

  mcam_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root_val)
  );

  mcam_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (entry.sum),
    .divisor  (entry.count),
    .done     (div_done),
    .quotient (quot)
  );

`ifndef NO_ASSERTIONS
  // The final result of a report always belongs to the top channel
  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last |-> result.channel_out == CH_W'(CHANNELS - 1))
    else $error("last flag on a result that is not the top channel");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || result.ready))
    else $error("output register loaded while a result was still pending");

  // Releasing a report empties every channel
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    clear_all |=> vld == '0)
    else $error("channel entries still valid after a released report");

  // Root completion only arrives while the sample waits for it
  a_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("square root finished outside the root wait state");
`endif

endmodule

// File: rtl/mcam_root.sv
// Bit-serial integer square root: floor(sqrt(radicand << 16)), one root bit per cycle
module mcam_root import mcam_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SSQ_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;
  logic              last_step;

  // One restoring step
  assign rem_sh    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = (rem_sh >= trial);
  assign last_step = (step == STEP_W'(ROOT_W - 1));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {radicand, {(RAD_W - SSQ_W){1'b0}}};
      rem  <= '0;
      root <= '0;
      step <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
      step <= step + 1'b1;
    end
  end

endmodule

// File: rtl/mcam_div.sv
// Restoring divider: sum / count, one quotient bit per cycle
module mcam_div import mcam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic              last_step;

  // Quotient register shifts the dividend out as quotient bits come in
  assign rem_sh    = {rem, quotient[SUM_W-1]};
  assign fits      = (rem_sh >= {1'b0, dvs});
  assign diff      = rem_sh - {1'b0, dvs};
  assign last_step = (step == STEP_W'(SUM_W - 1));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      step     <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], fits};
      rem      <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step     <= step + 1'b1;
    end
  end

endmodule

// File: test/multichannel_accel_magnitude_averager_tb.sv
`timescale 1ns / 100ps

module multichannel_accel_magnitude_averager_tb;
  import mcam_pkg::*;

  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 55;

  // One sample or report item
  typedef struct {
    logic                          mode;
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } accel_item_t;

  // One expected average
  typedef struct {
    logic [CH_W-1:0]  channel;
    logic [AVG_W-1:0] average;
    logic             last;
  } channel_average_t;

  // Tracks per-channel magnitude sums and counts, queues the averages a report releases
  class magnitude_average_tracker;
    logic [SUM_W-1:0] sums [CHANNELS];
    logic [CNT_W-1:0] counts [CHANNELS];
    logic [CNT_W-1:0] min_samples;
    channel_average_t pending_averages[$];
    int               mismatches;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        sums[i]   = '0;
        counts[i] = '0;
      end
      min_samples = MIN_SAMPLES_RESET;
      mismatches  = 0;
    endfunction

    // floor(sqrt(sq * 2^16)): magnitude with 8 fraction bits
    function longint unsigned root_q8(longint unsigned sq);
      longint unsigned radicand;
      longint unsigned root;
      longint unsigned trial;
      radicand = sq << 16;
      root     = 0;
      for (int b = 26; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function bit counts_full_enough();
      for (int i = 0; i < CHANNELS; i++) begin
        if (counts[i] < min_samples) begin
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Returns 0 when the block ignores the item
    function bit note_item(accel_item_t it);
      int              ch;
      longint          sx;
      longint          sy;
      longint          sz;
      longint unsigned sq;
      longint unsigned mag;
      longint unsigned total;
      longint unsigned sum_cap;
      longint unsigned quot;
      channel_average_t res;
      sum_cap = (64'd1 << SUM_W) - 1;
      ch      = it.channel;
      if (it.mode == MODE_SAMPLE) begin
        if (ch >= CHANNELS) begin
          return 1'b0;
        end
        if (counts[ch] == COUNT_MAX) begin
          return 1'b0;
        end
        sx  = it.accel_x;
        sy  = it.accel_y;
        sz  = it.accel_z;
        sq  = sx * sx + sy * sy + sz * sz;
        mag = root_q8(sq);
        if (mag > MAG_MAX) begin
          mag = MAG_MAX;
        end
        total = 64'(sums[ch]) + mag;
        if (total > sum_cap) begin
          total = sum_cap;
        end
        sums[ch]   = total[SUM_W-1:0];
        counts[ch] = counts[ch] + 1'b1;
        return 1'b1;
      end
      // Report: release only when every channel has enough samples
      if (!counts_full_enough()) begin
        return 1'b1;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        quot = 0;
        if (counts[i] != 0) begin
          quot = 64'(sums[i]) / 64'(counts[i]);
        end
        res.channel = CH_W'(i);
        res.average = quot[AVG_W-1:0];
        res.last    = (i == CHANNELS - 1);
        pending_averages.insert(pending_averages.size(), res);
        sums[i]   = '0;
        counts[i] = '0;
      end
      return 1'b1;
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endtask

    task check_average(logic [CH_W-1:0] ch, logic [AVG_W-1:0] avg, logic lst);
      channel_average_t exp;
      if (pending_averages.size() == 0) begin
        log_mismatch($sformatf("unexpected average ch=%0d avg=%0h last=%0b", ch, avg, lst));
        return;
      end
      exp = pending_averages.pop_front();
      if (ch !== exp.channel) begin
        log_mismatch($sformatf("channel_out %0d, want %0d", ch, exp.channel));
      end
      if (avg !== exp.average) begin
        log_mismatch($sformatf("ch %0d average %0h, want %0h", exp.channel, avg, exp.average));
      end
      if (lst !== exp.last) begin
        log_mismatch($sformatf("ch %0d last %0b, want %0b", exp.channel, lst, exp.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   tx_burst;
  int   stall_cycles;
  magnitude_average_tracker tracker;

  mcam_sample_if smp ();
  mcam_result_if res ();
  mcam_cfg_if    cfg_bus ();

  multichannel_accel_magnitude_averager u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_bus)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic accel_item_t sample_of(int ch, logic signed [SAMPLE_BITS-1:0] x,
                                            logic signed [SAMPLE_BITS-1:0] y,
                                            logic signed [SAMPLE_BITS-1:0] z);
    accel_item_t it;
    it.mode    = MODE_SAMPLE;
    it.channel = CH_W'(ch);
    it.accel_x = x;
    it.accel_y = y;
    it.accel_z = z;
    return it;
  endfunction

  function automatic accel_item_t report_item();
    accel_item_t it;
    it.mode    = MODE_REPORT;
    it.channel = CH_W'($urandom);
    it.accel_x = SAMPLE_BITS'($urandom);
    it.accel_y = SAMPLE_BITS'($urandom);
    it.accel_z = SAMPLE_BITS'($urandom);
    return it;
  endfunction

  // Mix of extremes, small values and full-range values
  function automatic logic signed [SAMPLE_BITS-1:0] random_axis();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Sender: random gap before each item, with gap-free bursts
  task automatic send_item(accel_item_t it, output bit took_effect);
    int gap;
    if (tx_burst > 0) begin
      gap = 0;
      tx_burst--;
    end else if ($urandom_range(0, 7) == 0) begin
      tx_burst = $urandom_range(5, 20);
      gap      = 0;
    end else begin
      gap = $urandom_range(0, 9);
    end
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid   <= 1'b1;
    smp.mode    <= it.mode;
    smp.channel <= it.channel;
    smp.accel_x <= it.accel_x;
    smp.accel_y <= it.accel_y;
    smp.accel_z <= it.accel_z;
    do @(posedge clk); while (!smp.ready);
    took_effect = tracker.note_item(it);
  endtask

  // Hold the sender until every released average has come back
  task automatic drain_results(int settle);
    smp.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_averages.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_min_samples(logic [CNT_W-1:0] value);
    drain_results(SETTLE_CYCLES);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.min_samples <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tracker.min_samples = value;
  endtask

  // Mostly fill-then-report rounds; some early reports and stray channels
  task automatic run_random_phase(logic [CNT_W-1:0] min_val, int budget);
    accel_item_t it;
    bit          took;
    int          done;
    done = 0;
    write_min_samples(min_val);
    while (done < budget) begin
      if (tracker.counts_full_enough() && $urandom_range(0, 2) != 0) begin
        it = report_item();
      end else begin
        case ($urandom_range(0, 19))
          0: it = report_item();
          1: it = sample_of($urandom_range(CHANNELS, 7), random_axis(), random_axis(),
                            random_axis());
          default: it = sample_of($urandom_range(0, CHANNELS - 1), random_axis(),
                                  random_axis(), random_axis());
        endcase
      end
      send_item(it, took);
      if (took) begin
        done++;
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_results(0);
      end
    end
  endtask

  // Result receiver: random stall before each average, with stall-free bursts
  initial begin
    int rx_wait;
    int rx_burst;
    int w;
    rx_wait   = 0;
    rx_burst  = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      w = rx_wait;
      if (!rst && res.valid && res.ready) begin
        tracker.check_average(res.channel_out, res.average, res.last);
        if (rx_burst > 0) begin
          rx_burst--;
          w = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_burst = $urandom_range(4, 15);
          w        = 0;
        end else begin
          w = $urandom_range(0, 9);
        end
      end
      if (w > 0) begin
        res.ready <= 1'b0;
        rx_wait = w - 1;
      end else begin
        res.ready <= 1'b1;
        rx_wait = 0;
      end
    end
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    bit took;
    tracker  = new();
    tx_burst = 0;
    rst                 <= 1'b1;
    smp.valid           <= 1'b0;
    smp.mode            <= MODE_SAMPLE;
    smp.channel         <= '0;
    smp.accel_x         <= '0;
    smp.accel_y         <= '0;
    smp.accel_z         <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.min_samples <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Report under the reset minimum with empty channels: nothing released
    send_item(report_item(), took);
    // Zero minimum: empty channels release averages of zero
    write_min_samples('0);
    send_item(report_item(), took);
    // Axis extremes on every channel, then stray channels
    send_item(sample_of(0, 16'sh8000, 16'sh8000, 16'sh8000), took);
    send_item(sample_of(1, 16'sh7fff, 16'sh7fff, 16'sh7fff), took);
    send_item(sample_of(2, 16'sh0000, 16'sh0000, 16'sh0000), took);
    send_item(sample_of(3, 16'shffff, 16'sh0001, 16'shffff), took);
    send_item(sample_of(4, 16'sh7fff, 16'sh8000, 16'sh0000), took);
    send_item(sample_of(5, 16'sh0001, 16'sh0000, 16'sh0000), took);
    send_item(sample_of(6, 16'sh1234, 16'sh8000, 16'sh7fff), took);
    send_item(sample_of(7, 16'sh8000, 16'sh8000, 16'sh8000), took);
    send_item(sample_of(0, 16'sh8000, 16'sh0000, 16'sh0000), took);
    send_item(sample_of(5, 16'sh0000, 16'sh0000, 16'sh7fff), took);
    send_item(report_item(), took);
    // Exact 3-4-5 magnitude on one channel, others empty
    send_item(sample_of(2, 16'sh0003, 16'sh0004, 16'sh0000), took);
    send_item(report_item(), took);

    // Randomized phases across minimum settings
    run_random_phase(16'd1, PHASE_ITEMS);
    run_random_phase(COUNT_MAX, PHASE_ITEMS);
    run_random_phase(CNT_W'($urandom_range(2, 4)), PHASE_ITEMS);
    run_random_phase(16'd1, PHASE_ITEMS);
    run_random_phase(CNT_W'($urandom_range(3, 6)), PHASE_ITEMS);
    run_random_phase('0, PHASE_ITEMS);

    drain_results(SETTLE_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
